// ===== design/ole_pkg.sv =====
`default_nettype none

package ole_pkg;

    localparam int MODE_W   = 4;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 3;
    localparam int LEN_W    = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_INS_HEAD   = 4'd0,
        MODE_INS_TAIL   = 4'd1,
        MODE_INS_POS    = 4'd2,
        MODE_INS_AFTER  = 4'd3,
        MODE_INS_BEFORE = 4'd4,
        MODE_DEL_HEAD   = 4'd5,
        MODE_DEL_TAIL   = 4'd6,
        MODE_DEL_POS    = 4'd7,
        MODE_DEL_AFTER  = 4'd8,
        MODE_DEL_BEFORE = 4'd9,
        MODE_READ       = 4'd10
    } mode_t;

    localparam logic [STATUS_W-1:0] STAT_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_BADPOS = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_BEYOND = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NOKEY  = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_NONB   = 3'd5;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 3'd6;

    // what every cell does this cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_DEL,
        CELL_ROT
    } cell_op_t;

    // where the shift boundary of an edit comes from
    typedef enum logic [1:0] {
        SRC_IDX,
        SRC_HIT,
        SRC_HIT_PREV,
        SRC_HIT_NEXT
    } sel_src_t;

    typedef struct packed {
        cell_op_t op;
        logic     sel;       // cell is at or past the edit point (wrap mark on rotate)
        logic     sel_prev;  // same flag of the cell toward the head
        logic     match_en;
        logic     valid;     // cell holds a live entry
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_DECIDE,
        S_APPLY,
        S_RESP,
        S_READ
    } state_t;

endpackage

`default_nettype wire

// ===== design/ordered_list_engine_core.sv =====
// Ordered list engine: a row of CAPACITY value cells kept in list order.
// Input channel (s_*): one request per transfer; s_tuser carries the mode,
// s_tdata the new value, the position and the match key.
// Output channel (m_*): status in m_tuser, value and length in m_tdata,
// m_tlast on the final result of a request.
// An edit request passes from its transfer through key compare in every
// cell, boundary decision along the hit chain, one parallel shift of the
// row, then the output register load.
// A read-out skips the shift: after key compare and decision it presents
// one entry per cycle while the output is not stalled, by rotating the
// live cells through the head cell.
// Requests are taken one at a time: s_tready is high only while the
// engine is idle, which includes while a finished result still waits
// in the output register.
// When m_tready is low a waiting result holds in the output register and
// the sequencer waits; nothing is lost or repeated.
// Reset empties the list at once; the cell contents need no clearing.
`default_nettype none

module ordered_list_engine_core #(
    parameter int CAPACITY = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // new_value[31:0], position[39:32], match_key[71:40]
    input  wire logic [3:0]  s_tuser,   // mode[3:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // item_value[31:0], list_length[36:32], zero[39:37]
    output logic [2:0]       m_tuser,   // status[2:0]
    output logic             m_tlast
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > ole_pkg::POS_W) ? CW : ole_pkg::POS_W) + 1;

    ole_pkg::state_t state_reg;
    ole_pkg::state_t state_next;

    logic [ole_pkg::MODE_W-1:0]   mode_reg;
    logic [ole_pkg::VALUE_W-1:0]  newv_reg;
    logic [ole_pkg::POS_W-1:0]    pos_reg;
    logic [ole_pkg::VALUE_W-1:0]  key_reg;
    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;
    logic [CW-1:0]                rd_reg;
    logic [CW-1:0]                rd_next;
    logic [ole_pkg::STATUS_W-1:0] status_reg;
    ole_pkg::cell_op_t            op_reg;
    logic [CAPACITY-1:0]          sel_reg;

    logic                         out_valid_reg;
    logic [ole_pkg::STATUS_W-1:0] out_status_reg;
    logic [ole_pkg::VALUE_W-1:0]  out_value_reg;
    logic                         out_last_reg;
    logic [ole_pkg::LEN_W-1:0]    out_len_reg;

    logic [ole_pkg::VALUE_W-1:0]  cell_val [CAPACITY];
    logic [CAPACITY-1:0]          hit;
    logic [CAPACITY-1:0]          valid_vec;
    logic [CAPACITY-1:0]          last_mark;
    logic [CAPACITY-1:0]          aft;
    ole_pkg::cell_ctrl_t          cell_ctrl [CAPACITY];

    logic                         accept;
    logic                         out_free;
    logic                         load_out;
    logic [ole_pkg::STATUS_W-1:0] load_status;
    logic [ole_pkg::VALUE_W-1:0]  load_value;
    logic                         load_last;
    ole_pkg::cell_op_t            cell_op;
    logic                         match_en;

    // decision signals
    logic [ole_pkg::STATUS_W-1:0] st_d;
    ole_pkg::cell_op_t            op_d;
    ole_pkg::sel_src_t            src_d;
    logic [CW-1:0]                idx_d;
    logic                         read_go;
    logic [CAPACITY-1:0]          sel_d;
    logic                         full;
    logic                         empty;
    logic                         found;
    logic                         after_any;
    logic [PW-1:0]                pos_w;
    logic [PW-1:0]                cnt_w;
    logic                         read_last;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ole_pkg::S_IDLE);
    assign out_free = !out_valid_reg || m_tready;

    assign full      = (count_reg == CW'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign found     = hit[CAPACITY-1];
    assign after_any = |aft;
    assign pos_w     = PW'(pos_reg);
    assign cnt_w     = PW'(count_reg);
    assign read_last = (rd_reg == count_reg - CW'(1));

    // cell row
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [ole_pkg::VALUE_W-1:0] prev_v;
            logic [ole_pkg::VALUE_W-1:0] next_v;
            logic                        sel_p;
            logic                        hit_i;

            assign valid_vec[gi] = (CW'(gi) < count_reg);
            assign last_mark[gi] = (CW'(gi) == count_reg - CW'(1));

            if (gi == 0)
            begin : g_head
                assign prev_v  = newv_reg;
                assign sel_p   = 1'b0;
                assign hit_i   = 1'b0;
                assign aft[gi] = 1'b0;
            end
            else
            begin : g_body
                assign prev_v  = cell_val[gi-1];
                assign sel_p   = sel_reg[gi-1];
                assign hit_i   = hit[gi-1];
                assign aft[gi] = valid_vec[gi] & hit[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign next_v = cell_val[gi];
            end
            else
            begin : g_inner
                assign next_v = cell_val[gi+1];
            end

            assign cell_ctrl[gi] = '{
                op:       cell_op,
                sel:      (cell_op == ole_pkg::CELL_ROT) ? last_mark[gi] : sel_reg[gi],
                sel_prev: sel_p,
                match_en: match_en,
                valid:    valid_vec[gi]
            };

            ole_cell u_cell (
                .clk        (clk),
                .ctrl       (cell_ctrl[gi]),
                .ins_value  (newv_reg),
                .prev_value (prev_v),
                .next_value (next_v),
                .head_value (cell_val[0]),
                .key        (key_reg),
                .hit_in     (hit_i),
                .value      (cell_val[gi]),
                .hit_out    (hit[gi])
            );
        end
    endgenerate

    // request decode against the registered hit chain
    always_comb
    begin
        st_d    = ole_pkg::STAT_OK;
        op_d    = ole_pkg::CELL_HOLD;
        src_d   = ole_pkg::SRC_IDX;
        idx_d   = '0;
        read_go = 1'b0;
        unique case (mode_reg)
            ole_pkg::MODE_INS_HEAD:
            begin
                if (full)
                    st_d = ole_pkg::STAT_FULL;
                else
                    op_d = ole_pkg::CELL_INS;
            end
            ole_pkg::MODE_INS_TAIL:
            begin
                idx_d = count_reg;
                if (full)
                    st_d = ole_pkg::STAT_FULL;
                else
                    op_d = ole_pkg::CELL_INS;
            end
            ole_pkg::MODE_INS_POS:
            begin
                idx_d = CW'(pos_w - PW'(1));
                if (pos_reg == '0)
                    st_d = ole_pkg::STAT_BADPOS;
                else if (pos_w > cnt_w + PW'(1))
                    st_d = ole_pkg::STAT_BEYOND;
                else if (full)
                    st_d = ole_pkg::STAT_FULL;
                else
                    op_d = ole_pkg::CELL_INS;
            end
            ole_pkg::MODE_INS_AFTER, ole_pkg::MODE_INS_BEFORE:
            begin
                src_d = (mode_reg == ole_pkg::MODE_INS_AFTER) ? ole_pkg::SRC_HIT_PREV
                                                              : ole_pkg::SRC_HIT;
                if (empty)
                    st_d = ole_pkg::STAT_EMPTY;
                else if (!found)
                    st_d = ole_pkg::STAT_NOKEY;
                else if (full)
                    st_d = ole_pkg::STAT_FULL;
                else
                    op_d = ole_pkg::CELL_INS;
            end
            ole_pkg::MODE_DEL_HEAD:
            begin
                if (empty)
                    st_d = ole_pkg::STAT_EMPTY;
                else
                    op_d = ole_pkg::CELL_DEL;
            end
            ole_pkg::MODE_DEL_TAIL:
            begin
                idx_d = count_reg - CW'(1);
                if (empty)
                    st_d = ole_pkg::STAT_EMPTY;
                else
                    op_d = ole_pkg::CELL_DEL;
            end
            ole_pkg::MODE_DEL_POS:
            begin
                idx_d = CW'(pos_w - PW'(1));
                if (pos_reg == '0)
                    st_d = ole_pkg::STAT_BADPOS;
                else if (pos_reg == ole_pkg::POS_W'(1))
                begin
                    if (empty)
                        st_d = ole_pkg::STAT_EMPTY;
                    else
                        op_d = ole_pkg::CELL_DEL;
                end
                else if (pos_w > cnt_w)
                    st_d = ole_pkg::STAT_BEYOND;
                else
                    op_d = ole_pkg::CELL_DEL;
            end
            ole_pkg::MODE_DEL_AFTER:
            begin
                src_d = ole_pkg::SRC_HIT_PREV;
                if (empty)
                    st_d = ole_pkg::STAT_EMPTY;
                else if (!found)
                    st_d = ole_pkg::STAT_NOKEY;
                else if (!after_any)
                    st_d = ole_pkg::STAT_NONB;
                else
                    op_d = ole_pkg::CELL_DEL;
            end
            ole_pkg::MODE_DEL_BEFORE:
            begin
                src_d = ole_pkg::SRC_HIT_NEXT;
                if (empty)
                    st_d = ole_pkg::STAT_EMPTY;
                else if (hit[0])
                    st_d = ole_pkg::STAT_NONB;
                else if (!found)
                    st_d = ole_pkg::STAT_NOKEY;
                else
                    op_d = ole_pkg::CELL_DEL;
            end
            ole_pkg::MODE_READ:
            begin
                if (empty)
                    st_d = ole_pkg::STAT_EMPTY;
                else
                    read_go = 1'b1;
            end
            default:
            begin
                st_d = ole_pkg::STAT_OK;
            end
        endcase
    end

    // shift boundary per cell
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            case (src_d)
                ole_pkg::SRC_IDX:      sel_d[i] = (CW'(i) >= idx_d);
                ole_pkg::SRC_HIT:      sel_d[i] = hit[i];
                ole_pkg::SRC_HIT_PREV: sel_d[i] = (i == 0) ? 1'b0 : hit[(i == 0) ? 0 : i-1];
                ole_pkg::SRC_HIT_NEXT: sel_d[i] = (i == CAPACITY-1) ? found
                                                  : hit[(i == CAPACITY-1) ? i : i+1];
                default:               sel_d[i] = 1'b0;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        cell_op     = ole_pkg::CELL_HOLD;
        match_en    = 1'b0;
        load_out    = 1'b0;
        load_status = status_reg;
        load_value  = '0;
        load_last   = 1'b1;
        count_next  = count_reg;
        rd_next     = rd_reg;
        unique case (state_reg)
            ole_pkg::S_IDLE:
            begin
                if (s_tvalid)
                    state_next = ole_pkg::S_MATCH;
            end
            ole_pkg::S_MATCH:
            begin
                match_en   = 1'b1;
                state_next = ole_pkg::S_DECIDE;
            end
            ole_pkg::S_DECIDE:
            begin
                rd_next    = '0;
                state_next = read_go ? ole_pkg::S_READ : ole_pkg::S_APPLY;
            end
            ole_pkg::S_APPLY:
            begin
                cell_op = op_reg;
                if (op_reg == ole_pkg::CELL_INS)
                    count_next = count_reg + CW'(1);
                else if (op_reg == ole_pkg::CELL_DEL)
                    count_next = count_reg - CW'(1);
                state_next = ole_pkg::S_RESP;
            end
            ole_pkg::S_RESP:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ole_pkg::S_IDLE;
                end
            end
            ole_pkg::S_READ:
            begin
                if (out_free)
                begin
                    load_out    = 1'b1;
                    load_status = ole_pkg::STAT_OK;
                    load_value  = cell_val[0];
                    load_last   = read_last;
                    cell_op     = ole_pkg::CELL_ROT;
                    rd_next     = rd_reg + CW'(1);
                    if (read_last)
                        state_next = ole_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ole_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ole_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= s_tuser;
            newv_reg <= s_tdata[31:0];
            pos_reg  <= s_tdata[39:32];
            key_reg  <= s_tdata[71:40];
        end
        if (state_reg == ole_pkg::S_DECIDE)
        begin
            status_reg <= st_d;
            op_reg     <= op_d;
            sel_reg    <= sel_d;
        end
        rd_reg <= rd_next;
        if (load_out)
        begin
            out_status_reg <= load_status;
            out_value_reg  <= load_value;
            out_last_reg   <= load_last;
            out_len_reg    <= ole_pkg::LEN_W'(count_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_len_reg, out_value_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== design/ole_cell.sv =====
`default_nettype none

module ole_cell (
    input  wire logic                       clk,
    input  wire ole_pkg::cell_ctrl_t        ctrl,
    input  wire logic [ole_pkg::VALUE_W-1:0] ins_value,
    input  wire logic [ole_pkg::VALUE_W-1:0] prev_value,
    input  wire logic [ole_pkg::VALUE_W-1:0] next_value,
    input  wire logic [ole_pkg::VALUE_W-1:0] head_value,
    input  wire logic [ole_pkg::VALUE_W-1:0] key,
    input  wire logic                       hit_in,
    output logic [ole_pkg::VALUE_W-1:0]      value,
    output logic                            hit_out
);

    logic [ole_pkg::VALUE_W-1:0] value_reg;
    logic [ole_pkg::VALUE_W-1:0] value_next;
    logic                        match_reg;
    logic                        match_next;

    always_comb
    begin
        value_next = value_reg;
        unique case (ctrl.op)
            ole_pkg::CELL_HOLD:
            begin
                value_next = value_reg;
            end
            ole_pkg::CELL_INS:
            begin
                // first cell of the boundary takes the new value, the rest move tailward
                if (ctrl.sel)
                begin
                    value_next = ctrl.sel_prev ? prev_value : ins_value;
                end
            end
            ole_pkg::CELL_DEL:
            begin
                if (ctrl.sel)
                begin
                    value_next = next_value;
                end
            end
            ole_pkg::CELL_ROT:
            begin
                // last live cell wraps the head around
                value_next = ctrl.sel ? head_value : next_value;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    assign match_next = ctrl.match_en ? (ctrl.valid && (value_reg == key)) : match_reg;

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        match_reg <= match_next;
    end

    assign value   = value_reg;
    assign hit_out = hit_in | match_reg;

endmodule

`default_nettype wire
